// File: design/lightgun_serial_pad_responder_assert.svh
// Assertion macros shared by the checker of the light-gun pad responder.
// Depends on nothing; the including module provides clk and rst.
`ifndef LIGHTGUN_SERIAL_PAD_RESPONDER_ASSERT_SVH
`define LIGHTGUN_SERIAL_PAD_RESPONDER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define LGSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgsp assertion failed");

// Next-cycle implication, off while reset is high.
`define LGSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgsp assertion failed");

// What must hold in the cycle after reset.
`define LGSP_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("lgsp assertion failed");

`endif

// File: design/lgsp_pkg.sv
// Types and constants of the light-gun pad responder.
// Used by the link, frame and top-level modules; depends on nothing.
package lgsp_pkg;

  typedef enum logic [1:0] {
    CMD_CLOCK   = 2'd0,
    CMD_SELECT  = 2'd1,
    CMD_BUTTONS = 2'd2,
    CMD_HIT     = 2'd3
  } cmd_t;

  localparam logic [7:0] ADDR_BYTE   = 8'h01;
  localparam logic [7:0] REPLY_ID    = 8'h63;
  localparam logic [7:0] REPORT_HDR  = 8'h5A;
  localparam logic [7:0] OPCODE_READ = 8'h42;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [15:0] SHOT_X     = 16'h0001;
  localparam logic [9:0]  SHOT_Y     = 10'h00A;
  localparam logic [2:0]  SHOT_FRAMES = 3'd4;
  localparam logic [2:0]  REPORT_LEN  = 3'd7;

  typedef struct packed {
    cmd_t        command;
    logic        txd;
    logic        select_level;
    logic        trigger;
    logic        button_a;
    logic        button_b;
    logic        offscreen;
    logic [15:0] hit_pos_x;
    logic [9:0]  hit_pos_y;
  } item_t;

  // Frame-side status that the link reads when it builds a report.
  typedef struct packed {
    logic [1:0]  held_buttons;
    logic        latched_trigger;
    logic [2:0]  shot_timer;
    logic [15:0] shot_x;
    logic [9:0]  shot_y;
  } frame_stat_t;

  typedef struct packed {
    logic rxd;
    logic data_ready;
    logic ack_pulse;
  } result_t;

endpackage

// File: design/lgsp_if.sv
// Valid/ready channel interfaces of the light-gun pad responder.
// Standalone; field widths follow the request and result definitions.
interface lgsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        txd;
  logic        select_level;
  logic        trigger;
  logic        button_a;
  logic        button_b;
  logic        offscreen;
  logic [15:0] hit_pos_x;
  logic [9:0]  hit_pos_y;

  modport source (
    output valid, command, txd, select_level, trigger, button_a, button_b,
           offscreen, hit_pos_x, hit_pos_y,
    input  ready
  );
  modport sink (
    input  valid, command, txd, select_level, trigger, button_a, button_b,
           offscreen, hit_pos_x, hit_pos_y,
    output ready
  );
endinterface

interface lgsp_out_if;
  logic valid;
  logic ready;
  logic rxd;
  logic data_ready;
  logic ack_pulse;

  modport source (output valid, rxd, data_ready, ack_pulse, input ready);
  modport sink (input valid, rxd, data_ready, ack_pulse, output ready);
endinterface

// File: design/lightgun_serial_pad_responder.sv
// Device side of a light-gun controller on a select-gated, bit-serial pad bus.
// Depends on lgsp_pkg, lgsp_if, lgsp_link and lgsp_frame.
//
// Takes one request per clock cycle while the result side keeps up, and returns
// exactly one result per request. A request is captured in an input register; the
// full state update and result are computed from it and stored in a result
// register once that register is free, and the result register drives the output.
// Throughput is set by that state update: one request per cycle whenever the
// result side keeps up. A stalled result register holds the input register, and
// the input side stops accepting only while both are full.
module lightgun_serial_pad_responder #(
  parameter int TX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  lgsp_in_if.sink     pad_in,
  lgsp_out_if.source  pad_out
);
  import lgsp_pkg::*;

  item_t       item;
  logic        item_valid;
  logic        step;
  logic        report_take;
  frame_stat_t fstat;
  result_t     res;

  assign step         = item_valid && (!pad_out.valid || pad_out.ready);
  assign pad_in.ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (pad_in.ready) begin
      item_valid <= pad_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pad_in.valid && pad_in.ready) begin
      item <= '{
        command:      cmd_t'(pad_in.command),
        txd:          pad_in.txd,
        select_level: pad_in.select_level,
        trigger:      pad_in.trigger,
        button_a:     pad_in.button_a,
        button_b:     pad_in.button_b,
        offscreen:    pad_in.offscreen,
        hit_pos_x:    pad_in.hit_pos_x,
        hit_pos_y:    pad_in.hit_pos_y
      };
    end
  end

  lgsp_link #(.TX_DEPTH(TX_DEPTH)) u_link (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .fstat       (fstat),
    .report_take (report_take),
    .res         (res)
  );

  lgsp_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .report_take (report_take),
    .fstat       (fstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_out.valid <= 1'b0;
    end else if (step) begin
      pad_out.valid <= 1'b1;
    end else if (pad_out.ready) begin
      pad_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pad_out.rxd        <= res.rxd;
      pad_out.data_ready <= res.data_ready;
      pad_out.ack_pulse  <= res.ack_pulse;
    end
  end

endmodule

// File: design/lgsp_frame.sv
// Per-frame button, trigger and hit-position state with the offscreen-shot timer.
// Depends on lgsp_pkg.
module lgsp_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  lgsp_pkg::item_t     item,
  input  logic                report_take,
  output lgsp_pkg::frame_stat_t fstat
);
  import lgsp_pkg::*;

  logic [1:0]  held_buttons;
  logic        latched_trigger;
  logic        live_trigger;
  logic [15:0] shot_x;
  logic [9:0]  shot_y;
  logic [2:0]  shot_timer;
  logic        prev_offscreen;
  logic [2:0]  timer_dec;
  logic        shot_start;

  assign timer_dec  = (shot_timer != 3'd0) ? shot_timer - 3'd1 : 3'd0;
  // A new shot starts only on a fresh press once the previous one has run out.
  assign shot_start = item.offscreen && !prev_offscreen && (timer_dec == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_buttons    <= '0;
      latched_trigger <= 1'b0;
      live_trigger    <= 1'b0;
      shot_x          <= '0;
      shot_y          <= '0;
      shot_timer      <= '0;
      prev_offscreen  <= 1'b0;
    end else if (step) begin
      case (item.command)
        CMD_BUTTONS: begin
          live_trigger    <= item.trigger;
          latched_trigger <= latched_trigger | item.trigger;
          held_buttons    <= {item.button_b, item.button_a};
          shot_timer      <= shot_start ? SHOT_FRAMES : timer_dec;
          prev_offscreen  <= item.offscreen;
        end
        CMD_HIT: begin
          shot_x <= item.hit_pos_x;
          shot_y <= item.hit_pos_y;
        end
        CMD_CLOCK: begin
          if (report_take) begin
            shot_x          <= SHOT_X;
            shot_y          <= SHOT_Y;
            latched_trigger <= live_trigger;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign fstat = '{
    held_buttons:    held_buttons,
    latched_trigger: latched_trigger,
    shot_timer:      shot_timer,
    shot_x:          shot_x,
    shot_y:          shot_y
  };

endmodule

// File: design/lgsp_link.sv
// Serial link engine: select tracking, command byte shifter and reply byte buffer.
// Depends on lgsp_pkg.
module lgsp_link #(
  parameter int TX_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  lgsp_pkg::item_t       item,
  input  lgsp_pkg::frame_stat_t fstat,
  output logic                  report_take,
  output lgsp_pkg::result_t     res
);
  import lgsp_pkg::*;

  localparam int IDX_W = $clog2(TX_DEPTH);

  typedef enum logic [1:0] {PH_ADDR, PH_CMD, PH_XFER, PH_IDLE} phase_t;

  logic             selected, selected_next;
  phase_t           phase, phase_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic [7:0]       tx_bytes [TX_DEPTH];
  logic [IDX_W-1:0] tx_index, tx_index_next;
  logic [2:0]       tx_left, tx_left_next;

  logic       load_hdr;
  logic [7:0] hdr_byte;
  logic       clear_report;
  logic [7:0] byte_in;
  logic [7:0] tx_cur;
  logic       rxd, ack;
  logic       shot_on;
  logic [7:0] btn1, btn2;
  logic [15:0] rep_x;
  logic [9:0]  rep_y;

  assign tx_cur  = tx_bytes[tx_index];
  assign shot_on = fstat.shot_timer != 3'd0;

  // Report bytes; during a shot the trigger bit is pressed on the middle two frames.
  always_comb begin
    btn1 = IDLE_BYTE ^ {4'b0, fstat.held_buttons[0], 3'b0};
    btn2 = IDLE_BYTE ^ {1'b0, fstat.held_buttons[1], fstat.latched_trigger, 5'b0};
    if (shot_on) begin
      btn2[5] = !(fstat.shot_timer == 3'd2 || fstat.shot_timer == 3'd3);
    end
    rep_x = shot_on ? SHOT_X : fstat.shot_x;
    rep_y = shot_on ? SHOT_Y : fstat.shot_y;
  end

  always_comb begin
    selected_next  = selected;
    phase_next     = phase;
    bit_index_next = bit_index;
    rx_shift_next  = rx_shift;
    tx_index_next  = tx_index;
    tx_left_next   = tx_left;
    load_hdr       = 1'b0;
    hdr_byte       = REPLY_ID;
    report_take    = 1'b0;
    clear_report   = 1'b0;
    rxd            = 1'b1;
    ack            = 1'b0;
    byte_in            = rx_shift;
    byte_in[bit_index] = item.txd;

    case (item.command)
      CMD_CLOCK: begin
        if (selected) begin
          if (tx_left != 3'd0) begin
            rxd = tx_cur[bit_index];
          end
          rx_shift_next  = byte_in;
          bit_index_next = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            if (tx_left != 3'd0) begin
              tx_index_next = tx_index + 1'b1;
              tx_left_next  = tx_left - 3'd1;
            end
            case (phase)
              PH_ADDR: begin
                if (byte_in != ADDR_BYTE) begin
                  phase_next = PH_IDLE;
                end else begin
                  load_hdr      = 1'b1;
                  hdr_byte      = REPLY_ID;
                  tx_index_next = '0;
                  tx_left_next  = 3'd1;
                  phase_next    = PH_CMD;
                end
              end
              PH_CMD: begin
                load_hdr      = 1'b1;
                hdr_byte      = REPORT_HDR;
                tx_index_next = '0;
                if (byte_in == OPCODE_READ) begin
                  phase_next   = PH_XFER;
                  report_take  = 1'b1;
                  tx_left_next = REPORT_LEN;
                end else begin
                  phase_next   = PH_IDLE;
                  clear_report = 1'b1;
                  tx_left_next = 3'd0;
                end
              end
              default: begin
              end
            endcase
            ack = tx_left_next != 3'd0;
          end
        end
      end
      CMD_SELECT: begin
        // Only a rising select restarts the transfer.
        if (!selected && item.select_level) begin
          phase_next     = PH_ADDR;
          bit_index_next = '0;
          tx_index_next  = '0;
          tx_left_next   = '0;
        end
        selected_next = item.select_level;
      end
      default: begin
      end
    endcase
  end

  assign res = '{
    rxd:        rxd,
    data_ready: selected_next && (bit_index_next == 3'd0) && (tx_left_next != 3'd0),
    ack_pulse:  ack
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      selected  <= 1'b0;
      phase     <= PH_ADDR;
      bit_index <= '0;
      rx_shift  <= '0;
      tx_index  <= '0;
      tx_left   <= '0;
    end else if (step) begin
      selected  <= selected_next;
      phase     <= phase_next;
      bit_index <= bit_index_next;
      rx_shift  <= rx_shift_next;
      tx_index  <= tx_index_next;
      tx_left   <= tx_left_next;
    end
  end

  // Reply buffer; entries 0 to 6 are written before they are sent; others never are.
  always_ff @(posedge clk) begin
    if (step) begin
      if (load_hdr) begin
        tx_bytes[0] <= hdr_byte;
      end
      if (report_take) begin
        tx_bytes[1] <= btn1;
        tx_bytes[2] <= btn2;
        tx_bytes[3] <= rep_x[7:0];
        tx_bytes[4] <= rep_x[15:8];
        tx_bytes[5] <= rep_y[7:0];
        tx_bytes[6] <= {6'b0, rep_y[9:8]};
      end
      if (clear_report) begin
        tx_bytes[1] <= '0;
        tx_bytes[2] <= '0;
      end
    end
  end

endmodule

// File: design/lgsp_checker.sv
// Port-level checker for the light-gun pad responder, with its bind statement.
// Depends on lightgun_serial_pad_responder_assert.svh.
`include "lightgun_serial_pad_responder_assert.svh"

module lgsp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic rxd,
  input logic data_ready,
  input logic ack_pulse
);

  // An acknowledge only follows a byte that leaves reply bytes, so DSR must be up.
  `LGSP_ASSERT_IMP(a_ack_has_dsr, out_valid && ack_pulse, data_ready)

  // The input side only stalls while a result is waiting.
  `LGSP_ASSERT_IMP(a_stall_when_full, !in_ready, out_valid)

  `LGSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(rxd) && $stable(data_ready) && $stable(ack_pulse))

  `LGSP_ASSERT_RST(a_rst_empty, !out_valid)

endmodule

bind lightgun_serial_pad_responder lgsp_checker u_lgsp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pad_in.valid),
  .in_ready   (pad_in.ready),
  .out_valid  (pad_out.valid),
  .out_ready  (pad_out.ready),
  .rxd        (pad_out.rxd),
  .data_ready (pad_out.data_ready),
  .ack_pulse  (pad_out.ack_pulse)
);
